// ----- hdl/mpq_pkg.sv -----
package mpq_pkg;
    localparam int VALUE_RANGE_DEF = 1024;
    localparam int COUNT_WIDTH_DEF = 11;
    localparam int KIND_W = 3;
    localparam int OPERAND_W = 20;

    typedef enum logic [2:0] {
        K_ADD  = 3'd0,
        K_REM  = 3'd1,
        K_DIFF = 3'd2,
        K_SUM  = 3'd3,
        K_PROD = 3'd4
    } t_kind;

    typedef struct packed {
        logic start;
        logic [OPERAND_W-1:0] dividend;
        logic [OPERAND_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [OPERAND_W-1:0] quot;
        logic rem_zero;
    } t_div_rsp;
endpackage

// ----- hdl/mpq_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module mpq_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpq_pkg::t_div_req i_req,
    output mpq_pkg::t_div_rsp o_rsp
);
    localparam int W = mpq_pkg::OPERAND_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] r_quot, r_div, r_rem;
    logic [CW-1:0] r_cnt;
    logic r_busy, r_done;
    logic [W:0] trial;

    always_comb begin
        trial = {r_rem, r_quot[W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quot <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (trial >= {1'b0, r_div}) begin
                    r_rem  <= W'(trial - {1'b0, r_div});
                    r_quot <= {r_quot[W-2:0], 1'b1};
                end else begin
                    r_rem  <= trial[W-1:0];
                    r_quot <= {r_quot[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem_zero = (r_rem == '0);
endmodule

// ----- hdl/multiset_pair_query_engine_unit.sv -----
// Multiset pair query engine. One transaction in, one result out; the block is busy
// between them. After reset a clearing pass wipes the count store before the first
// item is taken. Add and remove go through a read state and a write state and then
// present their result; an out-of-range add or remove value or an unknown kind
// answers in the next cycle. A difference or sum query walks candidate values
// through the presence store's one read port, two reads per candidate; a sum query
// stops after x+1 candidates and any query stops at the first hit. A product query
// tries each divisor j with j*j <= x and j < VALUE_RANGE through a bit-serial
// divider, with two presence reads when j divides x; x = 0 answers in the next
// cycle.
module multiset_pair_query_engine_unit #(
    parameter int VALUE_RANGE = mpq_pkg::VALUE_RANGE_DEF,
    parameter int COUNT_WIDTH = mpq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [mpq_pkg::KIND_W-1:0]     i_kind,
    input  logic [mpq_pkg::OPERAND_W-1:0]  i_operand,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_answer,
    output logic                           o_error
);
    localparam int W  = mpq_pkg::OPERAND_W;
    localparam int AW = $clog2(VALUE_RANGE);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_UPD_RD, S_UPD_WR, S_RD_A, S_RD_B, S_CHECK,
        S_DIV, S_DIV_WAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [COUNT_WIDTH:0] mem [VALUE_RANGE];  // {present, count}
    logic [COUNT_WIDTH:0] r_rd;
    logic [AW-1:0] r_clr;
    logic [2:0] r_kind;
    logic [W-1:0] r_x, r_j, r_b;
    logic r_pa, r_answer, r_error, r_bok;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [2*W-1:0] jsq;
    mpq_pkg::t_div_req div_req;
    mpq_pkg::t_div_rsp div_rsp;

    logic mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [COUNT_WIDTH:0] mem_wd;

    mpq_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign cnt = r_rd[COUNT_WIDTH-1:0];
    assign jsq = r_j * r_j;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_answer = r_answer;
    assign o_error = r_error;
    assign div_req.start = (r_state == S_DIV);
    assign div_req.dividend = r_x;
    assign div_req.divisor = r_j;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_x[AW-1:0];
        mem_wd = r_rd;
        mem_ra = r_j[AW-1:0];
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '0;
        end else if (r_state == S_UPD_WR) begin
            if (r_kind == mpq_pkg::K_ADD) begin
                if (cnt != '1) begin
                    mem_we = 1'b1;
                    mem_wd = {1'b1, cnt + 1'b1};
                end
            end else if (cnt != '0) begin
                mem_we = 1'b1;
                mem_wd = {(cnt != COUNT_WIDTH'(1)), cnt - 1'b1};
            end
        end
        if (r_state == S_UPD_RD) mem_ra = r_x[AW-1:0];
        else if (r_state == S_RD_B) mem_ra = r_b[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(VALUE_RANGE - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_kind <= i_kind;
                    r_x <= i_operand;
                    r_answer <= 1'b0;
                    r_error <= 1'b0;
                    case (i_kind)
                        mpq_pkg::K_ADD, mpq_pkg::K_REM: begin
                            if (i_operand >= W'(VALUE_RANGE)) begin
                                r_error <= 1'b1;
                                r_state <= S_OUT;
                            end else r_state <= S_UPD_RD;
                        end
                        mpq_pkg::K_DIFF, mpq_pkg::K_SUM: begin
                            r_j <= '0;
                            r_state <= S_RD_A;
                        end
                        mpq_pkg::K_PROD: begin
                            r_j <= W'(1);
                            if (i_operand == '0) r_state <= S_OUT;
                            else r_state <= S_DIV;
                        end
                        default: begin
                            r_error <= 1'b1;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_UPD_RD: r_state <= S_UPD_WR;
                S_UPD_WR: begin
                    if (r_kind == mpq_pkg::K_REM && cnt == '0) r_error <= 1'b1;
                    r_state <= S_OUT;
                end
                S_RD_A: begin
                    // partner of candidate j
                    if (r_kind == mpq_pkg::K_DIFF) begin
                        r_b <= r_j + r_x;
                        r_bok <= ({1'b0, r_j} + {1'b0, r_x}) < (W+1)'(VALUE_RANGE);
                    end else begin
                        r_b <= r_x - r_j;
                        r_bok <= (r_x - r_j) < W'(VALUE_RANGE);
                    end
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_pa <= r_rd[COUNT_WIDTH];
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_pa && r_bok && r_rd[COUNT_WIDTH] && r_j < W'(VALUE_RANGE)) begin
                        r_answer <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_kind == mpq_pkg::K_PROD) begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_DIV;
                    end else if (r_j == W'(VALUE_RANGE - 1) ||
                                 (r_kind == mpq_pkg::K_SUM && r_j == r_x)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_RD_A;
                    end
                end
                S_DIV: begin
                    if (jsq > (2*W)'(r_x) || r_j >= W'(VALUE_RANGE)) r_state <= S_OUT;
                    else r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: if (div_rsp.done) begin
                    if (div_rsp.rem_zero) begin
                        r_b <= div_rsp.quot;
                        r_bok <= div_rsp.quot < W'(VALUE_RANGE);
                        r_state <= S_RD_B;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/mpq_checker.sv -----
module mpq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_answer,
    input logic o_error
);
    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_answer) && $stable(o_error))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready after accept");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_answer && o_error)) else $error("answer with error");
endmodule

bind multiset_pair_query_engine_unit mpq_checker u_chk (.*);
